/* hw/rtl/template_tag_tokenizer_assert.svh */
// Assertion macros shared by the template tag tokenizer RTL.
`ifndef TEMPLATE_TAG_TOKENIZER_ASSERT_SVH
`define TEMPLATE_TAG_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define TTT_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TTT_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);

`else

`define TTT_ASSERT(lbl, ck, rs, prop, msg)
`define TTT_NEVER(lbl, ck, rs, cond, msg)

`endif

`endif

/* hw/rtl/tlex_pkg.sv */
// Types, character constants and decode functions of the template tag tokenizer.
`default_nettype none

package tlex_pkg;

  localparam int unsigned POS_BITS_DEF = 16;

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'd0,
    MODE_OPENED  = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_TAG     = 3'd3,
    MODE_NAME    = 3'd4,
    MODE_QNAME   = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    KIND_ERROR    = 4'd0,
    KIND_EOF      = 4'd1,
    KIND_IDENT    = 4'd2,
    KIND_OPEN     = 4'd3,
    KIND_HASH     = 4'd4,
    KIND_CLOSE    = 4'd5,
    KIND_TEXT     = 4'd6,
    KIND_SLASH    = 4'd7,
    KIND_QUESTION = 4'd8,
    KIND_HAT      = 4'd9,
    KIND_GREATER  = 4'd10,
    KIND_LBRACE   = 4'd11,
    KIND_RBRACE   = 4'd12
  } kind_t;

  typedef enum logic [2:0] {
    ERR_EOF_COMMENT = 3'd0,
    ERR_EOF_TAG     = 3'd1,
    ERR_NEWLINE     = 3'd2,
    ERR_BAD_CHAR    = 3'd3,
    ERR_NO_RBRACE   = 3'd4,
    ERR_STRAY_CLOSE = 3'd5,
    ERR_TOO_LONG    = 3'd6
  } err_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_HAT    = 8'h5E;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_LOW_LO = 8'h61;
  localparam logic [7:0] CH_LOW_HI = 8'h7A;
  localparam logic [7:0] CH_UP_LO  = 8'h41;
  localparam logic [7:0] CH_UP_HI  = 8'h5A;

  // Per-token fields that do not depend on the position width.
  typedef struct packed {
    kind_t      kind;
    err_t       code;
    logic [7:0] bad;
  } tok_info_t;

  // Outcome of one byte seen inside a tag with no close brace held.
  typedef struct packed {
    logic       emit;
    logic       hold;
    logic       to_name;
    logic       to_qname;
    kind_t      kind;
    err_t       code;
    logic [7:0] bad;
  } tf_t;

  function automatic tok_info_t mk_info(input kind_t k, input err_t c, input logic [7:0] bd);
    tok_info_t r;
    r.kind = k;
    r.code = c;
    r.bad  = bd;
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return b inside {[CH_DIG_LO:CH_DIG_HI], [CH_LOW_LO:CH_LOW_HI], [CH_UP_LO:CH_UP_HI]};
  endfunction

  function automatic logic is_name_char(input logic [7:0] b);
    return is_alnum(b) || (b == CH_UNDER) || (b == CH_DOT);
  endfunction

  function automatic tf_t tag_feed_f(input logic [7:0] b);
    tf_t r;
    r.emit     = 1'b0;
    r.hold     = 1'b0;
    r.to_name  = 1'b0;
    r.to_qname = 1'b0;
    r.kind     = KIND_ERROR;
    r.code     = ERR_EOF_COMMENT;
    r.bad      = 8'd0;
    if (b == CH_RBRACE) begin
      r.hold = 1'b1;
    end else if (b == CH_NL) begin
      r.emit = 1'b1;
      r.code = ERR_NEWLINE;
    end else if (b inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR}) begin
      r.emit = 1'b0;
    end else if (b == CH_HASH) begin
      r.emit = 1'b1;
      r.kind = KIND_HASH;
    end else if (b == CH_SLASH) begin
      r.emit = 1'b1;
      r.kind = KIND_SLASH;
    end else if (b == CH_QUEST) begin
      r.emit = 1'b1;
      r.kind = KIND_QUESTION;
    end else if (b == CH_HAT) begin
      r.emit = 1'b1;
      r.kind = KIND_HAT;
    end else if (b == CH_GT) begin
      r.emit = 1'b1;
      r.kind = KIND_GREATER;
    end else if (b == CH_LBRACE) begin
      r.emit     = 1'b1;
      r.kind     = KIND_LBRACE;
      r.to_qname = 1'b1;
    end else if (is_alnum(b) || (b == CH_UNDER)) begin
      r.to_name = 1'b1;
    end else begin
      r.emit = 1'b1;
      r.code = ERR_BAD_CHAR;
      r.bad  = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tlex_core.sv */
// Input register, lexer state and per-byte token decode of the tokenizer.
`default_nettype none
`include "template_tag_tokenizer_assert.svh"

module tlex_core #(
  parameter int unsigned POS_BITS = tlex_pkg::POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic                  bundle_free,
  output logic                  load,
  output logic [1:0]            load_count,
  output tlex_pkg::tok_info_t   load_info  [3],
  output logic [POS_BITS-1:0]   load_start [3],
  output logic [POS_BITS-1:0]   load_len   [3]
);
  import tlex_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] LEN_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] LEN_TWO = POS_BITS'(2);

  logic                in_r_valid;
  logic [7:0]          in_r_byte;
  logic                in_r_last;

  mode_t               mode;
  logic                held_valid;
  logic                held_lb;
  logic [POS_BITS-1:0] run_start;
  logic [POS_BITS-1:0] pos;
  logic [15:0]         depth;
  logic                halted;

  mode_t               mode_f;
  logic                held_v_f;
  logic                held_lb_f;
  logic [POS_BITS-1:0] run_f;
  logic [15:0]         depth_f;
  logic                failed;
  logic                use_tf;
  logic                too_long;
  logic                name_ch;
  tf_t                 tf;
  logic [POS_BITS-1:0] p_m1;
  logic [POS_BITS-1:0] e;

  logic                s_v     [4];
  tok_info_t           s_info  [4];
  logic [POS_BITS-1:0] s_start [4];
  logic [POS_BITS-1:0] s_len   [4];
  logic [1:0]          ntok;
  logic                fire;

  always_comb begin
    p_m1     = pos - LEN_ONE;
    e        = pos + LEN_ONE;
    tf       = tag_feed_f(in_r_byte);
    name_ch  = is_name_char(in_r_byte);
    too_long = (pos == POS_MAX);
    for (int i = 0; i < 4; i++) begin
      s_v[i]     = 1'b0;
      s_info[i]  = mk_info(KIND_ERROR, ERR_EOF_COMMENT, 8'd0);
      s_start[i] = '0;
      s_len[i]   = '0;
    end
    failed    = 1'b0;
    use_tf    = 1'b0;
    mode_f    = mode;
    held_v_f  = held_valid;
    held_lb_f = held_lb;
    run_f     = run_start;
    depth_f   = depth;

    if (too_long) begin
      s_v[0]     = 1'b1;
      s_info[0]  = mk_info(KIND_ERROR, ERR_TOO_LONG, 8'd0);
      s_start[0] = pos;
      failed     = 1'b1;
    end else begin
      case (mode)
        MODE_OPENED: begin
          if (in_r_byte == CH_BANG) begin
            mode_f  = MODE_COMMENT;
            depth_f = 16'd2;
          end else begin
            s_v[0]     = 1'b1;
            s_info[0]  = mk_info(KIND_OPEN, ERR_EOF_COMMENT, 8'd0);
            s_start[0] = run_start;
            s_len[0]   = LEN_TWO;
            mode_f     = MODE_TAG;
            use_tf     = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (in_r_byte == CH_LBRACE) begin
            if (depth != 16'hFFFF) begin
              depth_f = depth + 16'd1;
            end
          end else if (in_r_byte == CH_RBRACE) begin
            depth_f = depth - 16'd1;
            if (depth == 16'd1) begin
              mode_f = MODE_TEXT;
              run_f  = e;
            end
          end
        end
        MODE_TAG: begin
          if (held_valid) begin
            held_v_f = 1'b0;
            if (in_r_byte == CH_RBRACE) begin
              s_v[0]     = 1'b1;
              s_info[0]  = mk_info(KIND_CLOSE, ERR_EOF_COMMENT, 8'd0);
              s_start[0] = p_m1;
              s_len[0]   = LEN_TWO;
              mode_f     = MODE_TEXT;
              run_f      = e;
            end else begin
              s_v[0]     = 1'b1;
              s_info[0]  = mk_info(KIND_ERROR, ERR_BAD_CHAR, CH_RBRACE);
              s_start[0] = p_m1;
              failed     = 1'b1;
            end
          end else begin
            use_tf = 1'b1;
          end
        end
        MODE_NAME: begin
          if (!name_ch) begin
            s_v[0]     = 1'b1;
            s_info[0]  = mk_info(KIND_IDENT, ERR_EOF_COMMENT, 8'd0);
            s_start[0] = run_start;
            s_len[0]   = pos - run_start;
            mode_f     = MODE_TAG;
            use_tf     = 1'b1;
          end
        end
        MODE_QNAME: begin
          if (!name_ch) begin
            s_v[0]     = 1'b1;
            s_info[0]  = mk_info(KIND_IDENT, ERR_EOF_COMMENT, 8'd0);
            s_start[0] = run_start;
            s_len[0]   = pos - run_start;
            s_v[1]     = 1'b1;
            s_start[1] = pos;
            if (in_r_byte == CH_RBRACE) begin
              s_info[1] = mk_info(KIND_RBRACE, ERR_EOF_COMMENT, 8'd0);
              s_len[1]  = LEN_ONE;
              mode_f    = MODE_TAG;
            end else begin
              s_info[1] = mk_info(KIND_ERROR, ERR_NO_RBRACE, in_r_byte);
              failed    = 1'b1;
            end
          end
        end
        default: begin
          if (held_valid && held_lb && (in_r_byte == CH_LBRACE)) begin
            held_v_f = 1'b0;
            if (p_m1 != run_start) begin
              s_v[0]     = 1'b1;
              s_info[0]  = mk_info(KIND_TEXT, ERR_EOF_COMMENT, 8'd0);
              s_start[0] = run_start;
              s_len[0]   = p_m1 - run_start;
            end
            run_f  = p_m1;
            mode_f = MODE_OPENED;
          end else if (held_valid && !held_lb && (in_r_byte == CH_RBRACE)) begin
            held_v_f   = 1'b0;
            s_v[0]     = 1'b1;
            s_info[0]  = mk_info(KIND_ERROR, ERR_STRAY_CLOSE, 8'd0);
            s_start[0] = p_m1;
            failed     = 1'b1;
          end else begin
            held_v_f  = (in_r_byte == CH_LBRACE) || (in_r_byte == CH_RBRACE);
            held_lb_f = (in_r_byte == CH_LBRACE);
          end
        end
      endcase

      if (use_tf) begin
        if (tf.hold) begin
          held_v_f  = 1'b1;
          held_lb_f = 1'b0;
        end
        if (tf.emit) begin
          s_v[1]     = 1'b1;
          s_info[1]  = mk_info(tf.kind, tf.code, tf.bad);
          s_start[1] = pos;
          s_len[1]   = (tf.kind == KIND_ERROR) ? '0 : LEN_ONE;
          if (tf.kind == KIND_ERROR) begin
            failed = 1'b1;
          end
        end
        if (tf.to_qname) begin
          mode_f = MODE_QNAME;
          run_f  = e;
        end
        if (tf.to_name) begin
          mode_f = MODE_NAME;
          run_f  = pos;
        end
      end

      if (!failed && in_r_last) begin
        s_start[3] = e;
        case (mode_f)
          MODE_OPENED: begin
            s_v[2]     = 1'b1;
            s_info[2]  = mk_info(KIND_OPEN, ERR_EOF_COMMENT, 8'd0);
            s_start[2] = run_f;
            s_len[2]   = LEN_TWO;
            s_v[3]     = 1'b1;
            s_info[3]  = mk_info(KIND_ERROR, ERR_EOF_TAG, 8'd0);
          end
          MODE_COMMENT: begin
            s_v[3]    = 1'b1;
            s_info[3] = mk_info(KIND_ERROR, ERR_EOF_COMMENT, 8'd0);
          end
          MODE_TAG: begin
            s_v[3] = 1'b1;
            if (held_v_f) begin
              s_info[3]  = mk_info(KIND_ERROR, ERR_BAD_CHAR, CH_RBRACE);
              s_start[3] = pos;
            end else begin
              s_info[3] = mk_info(KIND_ERROR, ERR_EOF_TAG, 8'd0);
            end
          end
          MODE_NAME: begin
            s_v[2]     = 1'b1;
            s_info[2]  = mk_info(KIND_IDENT, ERR_EOF_COMMENT, 8'd0);
            s_start[2] = run_f;
            s_len[2]   = e - run_f;
            s_v[3]     = 1'b1;
            s_info[3]  = mk_info(KIND_ERROR, ERR_EOF_TAG, 8'd0);
          end
          MODE_QNAME: begin
            s_v[2]     = (e != run_f);
            s_info[2]  = mk_info(KIND_IDENT, ERR_EOF_COMMENT, 8'd0);
            s_start[2] = run_f;
            s_len[2]   = e - run_f;
            s_v[3]     = 1'b1;
            s_info[3]  = mk_info(KIND_ERROR, ERR_NO_RBRACE, 8'd0);
          end
          default: begin
            s_v[2]     = (e != run_f);
            s_info[2]  = mk_info(KIND_TEXT, ERR_EOF_COMMENT, 8'd0);
            s_start[2] = run_f;
            s_len[2]   = e - run_f;
            s_v[3]     = 1'b1;
            s_info[3]  = mk_info(KIND_EOF, ERR_EOF_COMMENT, 8'd0);
          end
        endcase
      end
    end
  end

  // Pack the valid candidate tokens into the low slots of the bundle.
  always_comb begin
    ntok = 2'd0;
    for (int j = 0; j < 3; j++) begin
      load_info[j]  = mk_info(KIND_ERROR, ERR_EOF_COMMENT, 8'd0);
      load_start[j] = '0;
      load_len[j]   = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (s_v[i] && !halted && (ntok != 2'd3)) begin
        load_info[ntok]  = s_info[i];
        load_start[ntok] = s_start[i];
        load_len[ntok]   = s_len[i];
        ntok             = ntok + 2'd1;
      end
    end
  end

  assign fire       = in_r_valid && ((ntok == 2'd0) || bundle_free);
  assign load       = fire && (ntok != 2'd0);
  assign load_count = ntok;
  assign in_ready   = !in_r_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_r_valid <= 1'b0;
      mode       <= MODE_TEXT;
      held_valid <= 1'b0;
      held_lb    <= 1'b0;
      run_start  <= '0;
      pos        <= '0;
      depth      <= '0;
      halted     <= 1'b0;
    end else begin
      if (in_ready) begin
        in_r_valid <= in_valid;
      end
      if (fire) begin
        if (in_r_last) begin
          mode       <= MODE_TEXT;
          held_valid <= 1'b0;
          held_lb    <= 1'b0;
          run_start  <= '0;
          pos        <= '0;
          depth      <= '0;
          halted     <= 1'b0;
        end else if (!halted) begin
          mode       <= mode_f;
          held_valid <= held_v_f;
          held_lb    <= held_lb_f;
          run_start  <= run_f;
          depth      <= depth_f;
          halted     <= failed;
          if (!too_long) begin
            pos <= e;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r_byte <= in_byte;
      in_r_last <= in_last;
    end
  end

  `TTT_ASSERT(a_stall_keeps, clk, rst, (in_r_valid && !fire) |=> in_r_valid, "stalled byte lost")
  `TTT_ASSERT(a_pos_step, clk, rst, (fire && !in_r_last && !halted && !too_long) |=> (pos == POS_BITS'($past(pos) + 1'b1)), "offset did not advance")
  `TTT_ASSERT(a_err_halts, clk, rst, (fire && failed && !in_r_last && !halted) |=> halted, "error did not halt")

endmodule

`default_nettype wire

/* hw/rtl/tlex_out.sv */
// Result bundle register and one-token-per-beat output serializer.
`default_nettype none
`include "template_tag_tokenizer_assert.svh"

module tlex_out #(
  parameter int unsigned POS_BITS = tlex_pkg::POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [1:0]            load_count,
  input  tlex_pkg::tok_info_t   load_info  [3],
  input  logic [POS_BITS-1:0]   load_start [3],
  input  logic [POS_BITS-1:0]   load_len   [3],
  output logic                  bundle_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            token_kind,
  output logic [POS_BITS-1:0]   token_start,
  output logic [POS_BITS-1:0]   token_length,
  output logic [2:0]            error_code,
  output logic [7:0]            error_byte,
  output logic                  last_of_run
);
  import tlex_pkg::*;

  logic [1:0]          cnt;
  logic [1:0]          idx;
  tok_info_t           b_info  [3];
  logic [POS_BITS-1:0] b_start [3];
  logic [POS_BITS-1:0] b_len   [3];
  logic [1:0]          last_idx;
  logic                out_fire;

  assign last_idx    = cnt - 2'd1;
  assign out_valid   = (cnt != 2'd0);
  assign out_fire    = out_valid && out_ready;
  assign bundle_free = (cnt == 2'd0) || (out_fire && (idx == last_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= load_count;
      idx <= 2'd0;
    end else if (out_fire) begin
      if (idx == last_idx) begin
        cnt <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_info  <= load_info;
      b_start <= load_start;
      b_len   <= load_len;
    end
  end

  assign token_kind   = b_info[idx].kind;
  assign error_code   = b_info[idx].code;
  assign error_byte   = b_info[idx].bad;
  assign token_start  = b_start[idx];
  assign token_length = b_len[idx];
  assign last_of_run  = (idx == last_idx);

  `TTT_NEVER(a_load_busy, clk, rst, load && !bundle_free, "bundle overwritten while busy")
  `TTT_NEVER(a_idx_range, clk, rst, out_valid && (idx >= cnt), "token index past bundle")
  `TTT_ASSERT(a_drain, clk, rst, (out_fire && last_of_run && !load) |=> !out_valid, "bundle not drained")

endmodule

`default_nettype wire

/* hw/rtl/template_tag_tokenizer.sv */
// An accepted byte passes the input register, then the bundle register, before its first token shows.
// Throughput: one byte per cycle while out_ready is high and each byte yields
//   at most one token; a byte of n tokens holds the serializer for n beats.
// Bytes that yield no token pass at one per cycle regardless of output stalls.
// Reset: synchronous, active high; clears lexer state and both valid flags.
`default_nettype none

// Top level of the brace-brace template tokenizer. One template byte per
// input beat; one token per output beat. The core holds the byte in an
// input register, decodes up to three tokens against the lexer state, and
// hands them as a bundle to the serializer, which drains them in order.
module template_tag_tokenizer #(
  parameter int unsigned POS_BITS = tlex_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          token_kind,
  output logic [POS_BITS-1:0] token_start,
  output logic [POS_BITS-1:0] token_length,
  output logic [2:0]          error_code,
  output logic [7:0]          error_byte,
  output logic                last_of_run
);
  import tlex_pkg::*;

  // Bundle handoff between the decode core and the serializer.
  logic                bundle_free;
  logic                load;
  logic [1:0]          load_count;
  tok_info_t           load_info  [3];
  logic [POS_BITS-1:0] load_start [3];
  logic [POS_BITS-1:0] load_len   [3];

  // Decode: hold the input beat, advance lexer state, build the token bundle.
  tlex_core #(
    .POS_BITS (POS_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .bundle_free (bundle_free),
    .load        (load),
    .load_count  (load_count),
    .load_info   (load_info),
    .load_start  (load_start),
    .load_len    (load_len)
  );

  // Serializer: drop one token per output beat, flag the last of each byte.
  tlex_out #(
    .POS_BITS (POS_BITS)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_count   (load_count),
    .load_info    (load_info),
    .load_start   (load_start),
    .load_len     (load_len),
    .bundle_free  (bundle_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .error_code   (error_code),
    .error_byte   (error_byte),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire
